/* hdl/timed_sorter_piston_controller_core_assert.svh */
// Assertion macros for the sorter piston controller.
// Both macros check at every rising clock edge and are disabled while reset is high.
// Synthesis builds see empty bodies.
`ifndef TIMED_SORTER_PISTON_CONTROLLER_CORE_ASSERT_SVH
`define TIMED_SORTER_PISTON_CONTROLLER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// Checks that prop holds at the same edge.
`define TSP_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("tsp: assertion failed");
// Checks that post holds in the cycle after pre.
`define TSP_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("tsp: assertion failed one cycle after its trigger");
`else
`define TSP_ASSERT(label, clk, rst, prop)
`define TSP_ASSERT_NEXT(label, clk, rst, pre, post)
`endif

`endif

/* hdl/tsp_pkg.sv */
`timescale 1ns / 1ps

package tsp_pkg;

   // Field and register widths
   localparam int DELAY_W   = 17;
   localparam int HOLD_W    = 19;
   localparam int DRIVE_W   = 3;
   localparam int CODE_W    = 2;
   localparam int BYTE_W    = 8;
   localparam int CSR_AW    = 4;
   localparam int CSR_DW    = 32;

   // Reset values of the configuration registers
   localparam logic [DELAY_W-1:0] FIRST_DELAY_RST = 17'd60000;
   localparam logic [DELAY_W-1:0] REARM_DELAY_RST = 17'd100000;
   localparam logic [HOLD_W-1:0]  HOLD_TIME_RST   = 19'd500000;

   // Drive bits: channel 1 is active low, so it idles high
   localparam logic [DRIVE_W-1:0] DRIVE_RST        = 3'b010;
   localparam logic [DRIVE_W-1:0] DRIVE_ACTIVE_LOW = 3'b010;

   // Register indexes (word address)
   typedef enum logic [1:0] {
      REG_FIRST_DELAY = 2'd0,
      REG_REARM_DELAY = 2'd1,
      REG_HOLD_TIME   = 2'd2
   } reg_index_type;

   // Configuration as seen by the datapath
   typedef struct packed {
      logic [DELAY_W-1:0] first_delay;
      logic [DELAY_W-1:0] rearm_delay;
      logic [HOLD_W-1:0]  hold_time;
      logic               load_first;  // first_delay being written this cycle
      logic [DELAY_W-1:0] load_value;  // value being written
   } cfg_type;

endpackage

/* hdl/tsp_csr.sv */
`timescale 1ns / 1ps

module tsp_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [tsp_pkg::CSR_AW-1:0]  paddr,
   input  logic [tsp_pkg::CSR_DW-1:0]  pwdata,
   output logic [tsp_pkg::CSR_DW-1:0]  prdata,
   output logic                        pready,
   output tsp_pkg::cfg_type            cfg
);
   import tsp_pkg::*;

   logic [DELAY_W-1:0] first_delay_ff, first_delay_in;
   logic [DELAY_W-1:0] rearm_delay_ff, rearm_delay_in;
   logic [HOLD_W-1:0]  hold_time_ff, hold_time_in;
   logic               wr_en;
   reg_index_type      reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_idx = reg_index_type'(paddr[CSR_AW-1:2]);

   // Write decode
   always_comb begin
      first_delay_in = first_delay_ff;
      rearm_delay_in = rearm_delay_ff;
      hold_time_in   = hold_time_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_FIRST_DELAY: begin
               first_delay_in = pwdata[DELAY_W-1:0];
            end
            REG_REARM_DELAY: begin
               rearm_delay_in = pwdata[DELAY_W-1:0];
            end
            REG_HOLD_TIME: begin
               hold_time_in = pwdata[HOLD_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_delay_ff <= FIRST_DELAY_RST;
         rearm_delay_ff <= REARM_DELAY_RST;
         hold_time_ff   <= HOLD_TIME_RST;
      end else begin
         first_delay_ff <= first_delay_in;
         rearm_delay_ff <= rearm_delay_in;
         hold_time_ff   <= hold_time_in;
      end
   end

   // Read mux
   always_comb begin
      case (reg_idx)
         REG_FIRST_DELAY: prdata = CSR_DW'(first_delay_ff);
         REG_REARM_DELAY: prdata = CSR_DW'(rearm_delay_ff);
         REG_HOLD_TIME:   prdata = CSR_DW'(hold_time_ff);
         default:         prdata = '0;
      endcase
   end

   assign cfg.first_delay = first_delay_ff;
   assign cfg.rearm_delay = rearm_delay_ff;
   assign cfg.hold_time   = hold_time_ff;
   assign cfg.load_first  = wr_en && (reg_idx == REG_FIRST_DELAY);
   assign cfg.load_value  = pwdata[DELAY_W-1:0];

endmodule

/* hdl/tsp_step.sv */
`timescale 1ns / 1ps

module tsp_step #(
   parameter int NUM_CHANNELS = 3
) (
   input  logic                                           is_byte,
   input  logic [tsp_pkg::BYTE_W-1:0]                     rx_byte,
   input  logic                                           sense0,
   input  logic                                           sense1_n,
   input  logic                                           sense2,
   input  tsp_pkg::cfg_type                               cfg,
   input  logic [NUM_CHANNELS-1:0]                        sel,
   input  logic [NUM_CHANNELS-1:0]                        lat,
   input  logic [NUM_CHANNELS-1:0]                        push,
   input  logic [NUM_CHANNELS-1:0][tsp_pkg::DELAY_W-1:0]  delay,
   input  logic [NUM_CHANNELS-1:0][tsp_pkg::HOLD_W-1:0]   hold,
   input  logic [tsp_pkg::DRIVE_W-1:0]                    drive,
   output logic [NUM_CHANNELS-1:0]                        sel_nx,
   output logic [NUM_CHANNELS-1:0]                        lat_nx,
   output logic [NUM_CHANNELS-1:0]                        push_nx,
   output logic [NUM_CHANNELS-1:0][tsp_pkg::DELAY_W-1:0]  delay_nx,
   output logic [NUM_CHANNELS-1:0][tsp_pkg::HOLD_W-1:0]   hold_nx,
   output logic [tsp_pkg::DRIVE_W-1:0]                    drive_nx,
   output logic [tsp_pkg::CODE_W-1:0]                     selected_nx,
   output logic [tsp_pkg::CODE_W-1:0]                     pushing_nx
);
   import tsp_pkg::*;

   logic [NUM_CHANNELS-1:0]              sense;
   logic [NUM_CHANNELS-1:0]              lat_a;
   logic [NUM_CHANNELS-1:0]              dly_act;
   logic [NUM_CHANNELS-1:0][DELAY_W-1:0] dly_dec;
   logic [NUM_CHANNELS-1:0]              dly_win;
   logic                                 dly_hit;
   logic [NUM_CHANNELS-1:0]              sel2, lat2, push2;
   logic [NUM_CHANNELS-1:0][DELAY_W-1:0] delay2;
   logic [NUM_CHANNELS-1:0][HOLD_W-1:0]  hold2;
   logic [NUM_CHANNELS-1:0][HOLD_W-1:0]  hold_dec;
   logic [NUM_CHANNELS-1:0][HOLD_W-1:0]  hold3;
   logic                                 hold_hit;
   logic [DRIVE_W-1:0]                   drive3;

   // Sensor sample, normalised to active high; extra channels have none
   always_comb begin
      sense = '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         if (i == 0) begin
            sense[i] = sense0;
         end else if (i == 1) begin
            sense[i] = ~sense1_n;
         end else if (i == 2) begin
            sense[i] = sense2;
         end
      end
   end

   assign lat_a = lat | sense;

   // Delay countdown: the first channel to expire wins and forces a full reset
   always_comb begin
      dly_hit = 1'b0;
      dly_win = '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         dly_act[i] = sel[i] & lat_a[i];
         dly_dec[i] = delay[i] - DELAY_W'(1);
         if (dly_act[i] && (dly_dec[i] == '0) && !dly_hit) begin
            dly_win[i] = 1'b1;
            dly_hit    = 1'b1;
         end
      end
   end

   always_comb begin
      if (dly_hit) begin
         sel2   = '0;
         lat2   = '0;
         push2  = dly_win;
         delay2 = {NUM_CHANNELS{cfg.rearm_delay}};
         hold2  = {NUM_CHANNELS{cfg.hold_time}};
      end else begin
         sel2  = sel;
         lat2  = lat_a;
         push2 = push;
         hold2 = hold;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            delay2[i] = dly_act[i] ? dly_dec[i] : delay[i];
         end
      end
   end

   // Hold countdown: pushing channels drive, the first to expire releases
   always_comb begin
      hold_hit = 1'b0;
      drive3   = drive;
      hold3    = hold2;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         hold_dec[i] = hold2[i] - HOLD_W'(1);
         if (push2[i] && !hold_hit) begin
            if (hold_dec[i] == '0) begin
               hold_hit = 1'b1;
               if (i < DRIVE_W) begin
                  drive3[i] = DRIVE_ACTIVE_LOW[i];
               end
            end else begin
               hold3[i] = hold_dec[i];
               if (i < DRIVE_W) begin
                  drive3[i] = ~DRIVE_ACTIVE_LOW[i];
               end
            end
         end
      end
   end

   // Serial byte versus tick
   always_comb begin
      sel_nx   = sel;
      lat_nx   = lat;
      push_nx  = push;
      delay_nx = delay;
      hold_nx  = hold;
      drive_nx = drive;
      if (is_byte) begin
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            sel_nx[i] = (rx_byte == BYTE_W'(i + 1));
         end
      end else begin
         drive_nx = drive3;
         if (hold_hit) begin
            sel_nx   = '0;
            lat_nx   = '0;
            push_nx  = '0;
            delay_nx = {NUM_CHANNELS{cfg.rearm_delay}};
            hold_nx  = {NUM_CHANNELS{cfg.hold_time}};
         end else begin
            sel_nx   = sel2;
            lat_nx   = lat2;
            push_nx  = push2;
            delay_nx = delay2;
            hold_nx  = hold3;
         end
      end
   end

   // Lowest set flag plus one, capped at the top code
   always_comb begin
      selected_nx = '0;
      pushing_nx  = '0;
      for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
         if (sel_nx[i]) begin
            selected_nx = (i + 1 > 3) ? 2'd3 : CODE_W'(i + 1);
         end
         if (push_nx[i]) begin
            pushing_nx = (i + 1 > 3) ? 2'd3 : CODE_W'(i + 1);
         end
      end
   end

endmodule

/* hdl/timed_sorter_piston_controller_core.sv */
// Sorter piston controller. Each request transfer is either a tick carrying the three
// sensor samples (opcode 0) or a received serial byte (opcode 1; bytes 1..3 select
// channel 0..2, anything else clears the selection). Every request yields exactly one
// response transfer carrying the drive outputs and the selected and pushing channel
// codes as they stand after that request. While no response is stalled, the block takes
// one request per clock and returns its response on the next clock: all state (flags,
// delay and hold counters) updates combinationally through the delay then the hold
// decrement. The response register is refilled in the same cycle its transfer is taken,
// so requests flow back to back; while a response is stalled the request side stalls
// with it. Configuration must be written over the APB-style port while no request is in
// flight; this is not enforced. Writing first_delay also reloads every delay counter.
`timescale 1ns / 1ps
`include "timed_sorter_piston_controller_core_assert.svh"

module timed_sorter_piston_controller_core #(
   parameter int NUM_CHANNELS = 3
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_opcode,
   input  logic [tsp_pkg::BYTE_W-1:0]          req_rx_byte,
   input  logic                                req_sense0,
   input  logic                                req_sense1_n,
   input  logic                                req_sense2,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_drive0,
   output logic                                rsp_drive1_n,
   output logic                                rsp_drive2,
   output logic [tsp_pkg::CODE_W-1:0]          rsp_selected,
   output logic [tsp_pkg::CODE_W-1:0]          rsp_pushing,
   // configuration port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [tsp_pkg::CSR_AW-1:0]          csr_paddr,
   input  logic [tsp_pkg::CSR_DW-1:0]          csr_pwdata,
   output logic [tsp_pkg::CSR_DW-1:0]          csr_prdata,
   output logic                                csr_pready
);
   import tsp_pkg::*;

   cfg_type cfg;

   logic [NUM_CHANNELS-1:0]              sel_ff, sel_in;
   logic [NUM_CHANNELS-1:0]              lat_ff, lat_in;
   logic [NUM_CHANNELS-1:0]              push_ff, push_in;
   logic [NUM_CHANNELS-1:0][DELAY_W-1:0] delay_ff, delay_in;
   logic [NUM_CHANNELS-1:0][HOLD_W-1:0]  hold_ff, hold_in;
   logic [DRIVE_W-1:0]                   drive_ff, drive_in;
   logic [CODE_W-1:0]                    selected_in, pushing_in;

   logic                                 rsp_valid_ff;
   logic [DRIVE_W-1:0]                   rsp_drive_ff;
   logic [CODE_W-1:0]                    rsp_selected_ff, rsp_pushing_ff;
   logic                                 accept;

   tsp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   tsp_step #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_step (
      .is_byte     (req_opcode),
      .rx_byte     (req_rx_byte),
      .sense0      (req_sense0),
      .sense1_n    (req_sense1_n),
      .sense2      (req_sense2),
      .cfg         (cfg),
      .sel         (sel_ff),
      .lat         (lat_ff),
      .push        (push_ff),
      .delay       (delay_ff),
      .hold        (hold_ff),
      .drive       (drive_ff),
      .sel_nx      (sel_in),
      .lat_nx      (lat_in),
      .push_nx     (push_in),
      .delay_nx    (delay_in),
      .hold_nx     (hold_in),
      .drive_nx    (drive_in),
      .selected_nx (selected_in),
      .pushing_nx  (pushing_in)
   );

   // Handshake: stall only while a response is held back
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   // Channel state
   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff   <= '0;
         lat_ff   <= '0;
         push_ff  <= '0;
         delay_ff <= {NUM_CHANNELS{FIRST_DELAY_RST}};
         hold_ff  <= {NUM_CHANNELS{HOLD_TIME_RST}};
         drive_ff <= DRIVE_RST;
      end else if (cfg.load_first) begin
         delay_ff <= {NUM_CHANNELS{cfg.load_value}};
      end else if (accept) begin
         sel_ff   <= sel_in;
         lat_ff   <= lat_in;
         push_ff  <= push_in;
         delay_ff <= delay_in;
         hold_ff  <= hold_in;
         drive_ff <= drive_in;
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_drive_ff    <= drive_in;
         rsp_selected_ff <= selected_in;
         rsp_pushing_ff  <= pushing_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_drive0   = rsp_drive_ff[0];
   assign rsp_drive1_n = rsp_drive_ff[1];
   assign rsp_drive2   = rsp_drive_ff[2];
   assign rsp_selected = rsp_selected_ff;
   assign rsp_pushing  = rsp_pushing_ff;

   // Checks
   `TSP_ASSERT(a_push_onehot, clock, reset, $onehot0(push_ff))
   `TSP_ASSERT(a_sel_onehot, clock, reset, $onehot0(sel_ff))
   `TSP_ASSERT_NEXT(a_accept_rsp, clock, reset, accept, rsp_valid_ff)
   `TSP_ASSERT_NEXT(a_first_load, clock, reset, cfg.load_first, delay_ff[0] == $past(cfg.load_value))

endmodule
